FILE: rtl/first_fit_block_allocator_defines.svh
// assertion macros used by the checker file
// no dependencies
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FFBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ffba_pkg.sv
// package for the first-fit block allocator
// holds op and status codes and default parameter values
package ffba_pkg;
  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 24;
  localparam int SIZE_W = 24;
  localparam int ADDR_W = 32;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_DONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ARG   = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_NOT_READY = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;
endpackage

FILE: rtl/first_fit_block_allocator.sv
// first-fit block allocator with coalescing, top level
// uses ffba_pkg; one block table memory walked by a small sequencer
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | in_op, in_request_size, in_address
//  out     | out_valid | out_stall | out_result_address, out_status
//
// one transaction at a time; allocate and free walk the block table entry by entry and
// shift later entries up to split a block or down to merge neighbours
// done clears by resetting the count, no sweep; table contents need no reset
// in_stall is high while a transaction is at work or a result waits for the output register
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_result_address,
  output logic [2:0]        out_status
);
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_SHUP_RD, S_SHUP_WR, S_SPLIT, S_LEFT_RD, S_LEFT_CHK,
    S_RIGHT_RD, S_RIGHT_CHK, S_SHDN_RD, S_SHDN_WR, S_RESP
  } state_t;

  state_t state_r;
  logic [SIZE_W:0]   mem_r [MAX_BLOCKS];
  logic [SIZE_W:0]   rd_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  wr_addr;
  logic [SIZE_W:0]   wr_data;

  logic [1:0]        op_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] base_r;
  logic              ready_r;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  k_r;
  logic [ADDR_W-1:0] pos_r;
  logic [SIZE_W-1:0] pay_r;
  logic [SIZE_W-1:0] keep_r;
  logic [CNT_W-1:0]  drop_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] res_r;
  logic [2:0]        status_r;

  logic [ADDR_W-1:0] hdr_pos;
  logic [SIZE_W-1:0] rd_pay;
  logic              rd_used;
  assign rd_pay  = rd_r[SIZE_W-1:0];
  assign rd_used = rd_r[SIZE_W];
  assign hdr_pos = pos_r + ADDR_W'(HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (we) mem_r[wr_addr] <= wr_data;
    rd_r <= mem_r[rd_addr];
  end

  always_comb begin
    rd_addr = idx_r[IDX_W-1:0];
    we = 1'b0;
    wr_addr = idx_r[IDX_W-1:0];
    wr_data = '0;
    case (state_r)
      S_SHUP_RD: rd_addr = IDX_W'(k_r - 1'b1);
      S_SHUP_WR: begin
        we = 1'b1;
        wr_addr = k_r[IDX_W-1:0];
        wr_data = rd_r;
      end
      S_SPLIT: begin
        we = 1'b1;
        wr_addr = IDX_W'(idx_r + 1'b1);
        wr_data = {1'b0, keep_r};
      end
      S_LEFT_RD: rd_addr = IDX_W'(idx_r - 1'b1);
      S_RIGHT_RD: rd_addr = IDX_W'(idx_r + 1'b1);
      S_SHDN_RD: rd_addr = IDX_W'(k_r + 1'b1);
      S_SHDN_WR: begin
        we = 1'b1;
        wr_addr = k_r[IDX_W-1:0];
        wr_data = rd_r;
      end
      default: ;
    endcase
    if (state_r == S_CHK && op_r == OP_ALLOC && !rd_used && rd_pay >= size_r) begin
      we = 1'b1;
      wr_data = {1'b1, rd_pay};
      if (rd_pay - size_r >= HDR && rd_pay != size_r && count_r < CNT_MAX)
        wr_data = {1'b1, size_r};
    end
    if (state_r == S_CHK && op_r == OP_FREE && hdr_pos == addr_r) begin
      we = 1'b1;
      wr_data = {1'b0, rd_pay};
    end
    if (state_r == S_LEFT_CHK && !rd_used && rd_pay != '0) begin
      we = 1'b1;
      wr_addr = IDX_W'(idx_r - 1'b1);
      wr_data = {1'b0, rd_pay + pay_r + HDR};
    end
    if (state_r == S_RIGHT_CHK && !rd_used && pay_r != '0) begin
      we = 1'b1;
      wr_data = {1'b0, rd_pay + pay_r + HDR};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      base_r <= '0;
      ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_op;
            size_r <= in_request_size;
            addr_r <= in_address;
            idx_r <= '0;
            pos_r <= base_r;
            res_r <= '0;
            status_r <= ST_OK;
            state_r <= S_RESP;
            case (op_t'(in_op))
              OP_INIT: begin
                if (in_address == '0) status_r <= ST_BAD_ARG;
                else if (ready_r) status_r <= ST_NOT_READY;
                else if (in_request_size <= HDR) status_r <= ST_BAD_ARG;
                else begin
                  keep_r <= in_request_size - HDR;
                  idx_r <= '1;
                  base_r <= in_address;
                  count_r <= CNT_W'(1);
                  ready_r <= 1'b1;
                  state_r <= S_SPLIT;
                end
              end
              OP_ALLOC: begin
                if (in_request_size == '0) status_r <= ST_BAD_ARG;
                else if (!ready_r) status_r <= ST_NOT_READY;
                else if (count_r == '0) status_r <= ST_NO_FIT;
                else state_r <= S_RD;
              end
              OP_FREE: begin
                if (in_address == '0) status_r <= ST_OK;
                else if (!ready_r) status_r <= ST_NOT_READY;
                else if (count_r == '0) status_r <= ST_NOT_FOUND;
                else state_r <= S_RD;
              end
              default: begin
                count_r <= '0;
                base_r <= '0;
                ready_r <= 1'b0;
              end
            endcase
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (op_r == OP_ALLOC) begin
            if (!rd_used && rd_pay >= size_r) begin
              res_r <= hdr_pos;
              state_r <= S_RESP;
              if (rd_pay - size_r >= HDR && rd_pay != size_r && count_r < CNT_MAX) begin
                keep_r <= rd_pay - size_r - HDR;
                k_r <= count_r;
                state_r <= (count_r == idx_r + 1'b1) ? S_SPLIT : S_SHUP_RD;
              end
            end else if (idx_r + 1'b1 == count_r) begin
              status_r <= ST_NO_FIT;
              state_r <= S_RESP;
            end else begin
              idx_r <= idx_r + 1'b1;
              pos_r <= hdr_pos + ADDR_W'(rd_pay);
              state_r <= S_RD;
            end
          end else begin
            if (hdr_pos == addr_r) begin
              pay_r <= rd_pay;
              state_r <= (idx_r != '0) ? S_LEFT_RD : S_RIGHT_RD;
            end else if (idx_r + 1'b1 == count_r) begin
              status_r <= ST_NOT_FOUND;
              state_r <= S_RESP;
            end else begin
              idx_r <= idx_r + 1'b1;
              pos_r <= hdr_pos + ADDR_W'(rd_pay);
              state_r <= S_RD;
            end
          end
        end
        S_SHUP_RD: state_r <= S_SHUP_WR;
        S_SHUP_WR: begin
          k_r <= k_r - 1'b1;
          state_r <= (k_r - 1'b1 == idx_r + 1'b1) ? S_SPLIT : S_SHUP_RD;
        end
        S_SPLIT: begin
          if (op_r == OP_ALLOC) count_r <= count_r + 1'b1;
          state_r <= S_RESP;
        end
        S_LEFT_RD: state_r <= S_LEFT_CHK;
        S_LEFT_CHK: begin
          if (!rd_used && rd_pay != '0) begin
            pay_r <= rd_pay + pay_r + HDR;
            drop_r <= idx_r;
            idx_r <= idx_r - 1'b1;
            k_r <= idx_r;
            state_r <= (idx_r + 1'b1 < count_r) ? S_SHDN_RD : S_RESP;
            count_r <= count_r - 1'b1;
          end else begin
            state_r <= S_RIGHT_RD;
          end
        end
        S_RIGHT_RD: state_r <= (idx_r + 1'b1 < count_r) ? S_RIGHT_CHK : S_RESP;
        S_RIGHT_CHK: begin
          if (!rd_used && pay_r != '0) begin
            drop_r <= '0;
            k_r <= idx_r + 1'b1;
            count_r <= count_r - 1'b1;
            state_r <= (idx_r + 2'd2 < count_r) ? S_SHDN_RD : S_RESP;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_SHDN_RD: state_r <= S_SHDN_WR;
        S_SHDN_WR: begin
          k_r <= k_r + 1'b1;
          if (k_r + 1'b1 < count_r) state_r <= S_SHDN_RD;
          else if (drop_r != '0) state_r <= S_RIGHT_RD;
          else state_r <= S_RESP;
          if (k_r + 1'b1 >= count_r) drop_r <= '0;
        end
        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid_r && !out_stall && state_r != S_RESP) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && (!out_valid_r || !out_stall)) begin
      out_result_address <= res_r;
      out_status <= status_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
endmodule

FILE: rtl/ffba_checker.sv
// port-level checker for the first-fit block allocator
// uses ffba_pkg and the assertion macros header; bound to the top level
`include "first_fit_block_allocator_defines.svh"
module ffba_checker
  import ffba_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ADDR_W-1:0] out_result_address,
  input logic [2:0]        out_status
);
  `FFBA_ASSERT_IMPL(a_status_range, out_valid, out_status <= ST_NOT_FOUND, "status out of range")
  `FFBA_ASSERT_IMPL(a_fail_zero, out_valid && out_status != ST_OK, out_result_address == '0, "failed transaction carries an address")
  `FFBA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted a second transaction while busy")
  `FFBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status), "stalled result changed")
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
